// File: hw/rtl/pcxd_pkg.sv
`default_nettype none

package pcxd_pkg;

    // Run-length code detection.
    localparam logic [7:0] RUN_CODE_MASK  = 8'hC0;
    localparam logic [5:0] RUN_COUNT_MASK = 6'h3F;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_RLE_ON     = 3'd0;
    localparam logic [2:0] REG_PLANES     = 3'd1;
    localparam logic [2:0] REG_BPP        = 3'd2;
    localparam logic [2:0] REG_LINE_BYTES = 3'd3;
    localparam logic [2:0] REG_WIDTH      = 3'd4;
    localparam logic [2:0] REG_HEIGHT     = 3'd5;

    localparam int          APB_AW        = 5;
    localparam logic [14:0] LINE_BYTES_MAX = 15'd16384;
    localparam logic [2:0]  PLANES_MAX     = 3'd4;
    localparam logic [15:0] LIMIT_CEIL     = 16'd32000;

    // Configuration as the datapath sees it, already saturated into range.
    typedef struct packed {
        logic        rle_on;
        logic [2:0]  planes;
        logic [2:0]  bpp;
        logic [14:0] lb;
        logic [15:0] w;
        logic [15:0] h;
    } t_cfg;

    // What one advance of the position unit yields.
    typedef struct packed {
        logic [11:0] row;
        logic [11:0] col;
        logic [1:0]  chan;
        logic        fill;
        logic        wr;
        logic        line_done;
        logic        ended;
    } t_step;

    // One result item.
    typedef struct packed {
        logic [11:0] row;
        logic [11:0] column;
        logic [1:0]  channel;
        logic [7:0]  value;
        logic        fill_alpha;
        logic        last_of_run;
        logic        end_of_image;
        logic        bad_run;
    } t_res;

endpackage

`default_nettype wire

// File: hw/rtl/pcxd_cfg.sv
`default_nettype none

module pcxd_cfg #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [pcxd_pkg::APB_AW-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    output pcxd_pkg::t_cfg                   o_cfg
);
    import pcxd_pkg::*;

    localparam logic [15:0] W_MAX = 16'(MAX_WIDTH);
    localparam logic [15:0] H_MAX = 16'(MAX_HEIGHT);

    logic        r_rle_on;
    logic [2:0]  r_planes;
    logic [2:0]  r_bpp;
    logic [14:0] r_lb;
    logic [12:0] r_w;
    logic [12:0] r_h;
    logic [2:0]  reg_idx;
    logic        wr_en;
    logic [15:0] w_ext;
    logic [15:0] h_ext;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rle_on <= 1'b1;
            r_planes <= 3'd1;
            r_bpp    <= 3'd1;
            r_lb     <= 15'd1;
            r_w      <= 13'd1;
            r_h      <= 13'd1;
        end else if (wr_en) begin
            case (reg_idx)
                REG_RLE_ON:     r_rle_on <= pwdata[0];
                REG_PLANES:     r_planes <= pwdata[2:0];
                REG_BPP:        r_bpp    <= pwdata[2:0];
                REG_LINE_BYTES: r_lb     <= pwdata[14:0];
                REG_WIDTH:      r_w      <= pwdata[12:0];
                REG_HEIGHT:     r_h      <= pwdata[12:0];
                default:        ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_RLE_ON:     prdata = {31'd0, r_rle_on};
            REG_PLANES:     prdata = {29'd0, r_planes};
            REG_BPP:        prdata = {29'd0, r_bpp};
            REG_LINE_BYTES: prdata = {17'd0, r_lb};
            REG_WIDTH:      prdata = {19'd0, r_w};
            REG_HEIGHT:     prdata = {19'd0, r_h};
            default:        prdata = 32'd0;
        endcase
    end

    // Out-of-range settings are used saturated.
    assign w_ext = {3'd0, r_w};
    assign h_ext = {3'd0, r_h};

    always_comb begin
        o_cfg.rle_on = r_rle_on;
        o_cfg.planes = (r_planes == 3'd0) ? 3'd1 :
                       (r_planes > PLANES_MAX) ? PLANES_MAX : r_planes;
        o_cfg.bpp    = (r_bpp == 3'd0) ? 3'd1 :
                       (r_bpp > PLANES_MAX) ? PLANES_MAX : r_bpp;
        o_cfg.lb     = (r_lb == 15'd0) ? 15'd1 :
                       (r_lb > LINE_BYTES_MAX) ? LINE_BYTES_MAX : r_lb;
        o_cfg.w      = (w_ext == 16'd0) ? 16'd1 : (w_ext > W_MAX) ? W_MAX : w_ext;
        o_cfg.h      = (h_ext == 16'd0) ? 16'd1 : (h_ext > H_MAX) ? H_MAX : h_ext;
    end

endmodule

`default_nettype wire

// File: hw/rtl/pcxd_pos.sv
`default_nettype none

module pcxd_pos #(
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire pcxd_pkg::t_cfg i_cfg,
    input  wire logic           i_adv,
    output pcxd_pkg::t_step     o_step
);
    import pcxd_pkg::*;

    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    logic [13:0]   r_bpl;
    logic [1:0]    r_plane;
    logic [13:0]   r_pixcol;
    logic [1:0]    r_bip;
    logic [RW-1:0] r_row;

    logic          planar;
    logic [13:0]   col;
    logic [14:0]   nbpl;
    logic [2:0]    nbip;
    logic [2:0]    nplane;
    logic [RW:0]   nrow;
    logic          pix_wrap;
    logic          plane_wrap;
    logic          line_done;
    logic [15:0]   row_ext;

    assign planar     = (i_cfg.planes > 3'd1);
    assign col        = planar ? r_bpl : r_pixcol;
    assign nbpl       = {1'b0, r_bpl} + 15'd1;
    assign nbip       = {1'b0, r_bip} + 3'd1;
    assign nplane     = {1'b0, r_plane} + 3'd1;
    assign nrow       = {1'b0, r_row} + {{RW{1'b0}}, 1'b1};
    assign pix_wrap   = (nbip >= i_cfg.bpp);
    assign plane_wrap = (nplane >= i_cfg.planes);
    assign line_done  = (nbpl >= i_cfg.lb);
    assign row_ext    = 16'(r_row);

    always_comb begin
        o_step.row       = row_ext[11:0];
        o_step.col       = col[11:0];
        o_step.chan      = planar ? r_plane : r_bip;
        o_step.fill      = planar ? (i_cfg.planes == 3'd3 && r_plane == 2'd2)
                                  : (i_cfg.bpp == 3'd3 && r_bip == 2'd2);
        o_step.wr        = ({2'd0, col} < i_cfg.w);
        o_step.line_done = line_done;
        o_step.ended     = line_done && plane_wrap && (16'(nrow) >= i_cfg.h);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpl    <= '0;
            r_plane  <= '0;
            r_pixcol <= '0;
            r_bip    <= '0;
            r_row    <= '0;
        end else if (i_adv) begin
            if (line_done) begin
                r_bpl    <= '0;
                r_bip    <= '0;
                r_pixcol <= '0;
                if (plane_wrap) begin
                    r_plane <= '0;
                    r_row   <= nrow[RW-1:0];
                end else begin
                    r_plane <= nplane[1:0];
                end
            end else begin
                r_bpl <= nbpl[13:0];
                if (pix_wrap) begin
                    r_bip    <= '0;
                    r_pixcol <= r_pixcol + 14'd1;
                end else begin
                    r_bip <= nbip[1:0];
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/pcx_rle_plane_decoder.sv
`default_nettype none

// A literal byte is stepped by the position unit in the run state into a held slot, and the
// flush state moves it to the master side; a new byte is accepted only back in idle. A run's
// value byte advances the position unit one decoded byte a cycle while the output is free.
// Output back-pressure stalls the position unit cycle for cycle.
// Reset is synchronous and active low; it restores register defaults and clears the position
// and run control state; the value, held and output data registers are not reset.
module pcx_rle_plane_decoder #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // Slave side: [7:0] code_byte.
    input  wire logic                        i_s_tvalid,
    output logic                             o_s_tready,
    input  wire logic [7:0]                  i_s_tdata,
    // Master side tdata: [11:0] row, [23:12] column, [25:24] channel, [33:26] value.
    output logic                             o_m_tvalid,
    input  wire logic                        i_m_tready,
    output logic [39:0]                      o_m_tdata,
    output logic                             o_m_tlast,
    // Master side tuser: [0] fill_alpha, [1] end_of_image, [2] bad_run.
    output logic [2:0]                       o_m_tuser,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [pcxd_pkg::APB_AW-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import pcxd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_RUN   = 3'b010,
        S_FLUSH = 3'b100
    } t_state;

    t_cfg   cfg;
    t_step  step;

    t_state r_state, n_state;
    logic   r_await, n_await;
    logic [5:0] r_pend, n_pend;
    logic   r_halt, n_halt;
    logic [7:0] r_val, n_val;
    logic [5:0] r_rem, n_rem;
    logic   r_ended, n_ended;
    t_res   r_held, n_held;
    logic   r_held_v, n_held_v;
    t_res   r_out, n_out;
    logic   r_ov, n_ov;

    logic   in_acc;
    logic   out_free;
    logic   adv;
    logic   is_code;
    t_res   step_res;

    pcxd_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    pcxd_pos #(
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_pos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_adv   (adv),
        .o_step  (step)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign in_acc     = i_s_tvalid & o_s_tready;
    assign out_free   = !r_ov || i_m_tready;
    assign adv        = (r_state == S_RUN) && out_free;
    assign is_code    = cfg.rle_on && ((i_s_tdata & RUN_CODE_MASK) == RUN_CODE_MASK);

    always_comb begin
        step_res              = '0;
        step_res.row          = step.row;
        step_res.column       = step.col;
        step_res.channel      = step.chan;
        step_res.value        = r_val;
        step_res.fill_alpha   = step.fill;
    end

    // The newest write is held back one step: only when the run is over is it known
    // which write was the last one of the byte.
    always_comb begin
        n_state  = r_state;
        n_await  = r_await;
        n_pend   = r_pend;
        n_halt   = r_halt;
        n_val    = r_val;
        n_rem    = r_rem;
        n_ended  = r_ended;
        n_held   = r_held;
        n_held_v = r_held_v;
        n_out    = r_out;
        n_ov     = r_ov && !i_m_tready;

        case (r_state)
            S_IDLE: begin
                if (in_acc && !r_halt) begin
                    if (r_await) begin
                        n_await = 1'b0;
                        n_pend  = '0;
                        n_val   = i_s_tdata;
                        n_rem   = r_pend;
                        n_state = S_RUN;
                    end else if (is_code) begin
                        if ((i_s_tdata[5:0] & RUN_COUNT_MASK) == 6'd0) begin
                            n_held         = '0;
                            n_held.bad_run = 1'b1;
                            n_held_v       = 1'b1;
                            n_ended        = 1'b0;
                            n_halt         = 1'b1;
                            n_state        = S_FLUSH;
                        end else begin
                            n_await = 1'b1;
                            n_pend  = i_s_tdata[5:0] & RUN_COUNT_MASK;
                        end
                    end else begin
                        n_val   = i_s_tdata;
                        n_rem   = 6'd1;
                        n_state = S_RUN;
                    end
                end
            end
            S_RUN: begin
                if (adv) begin
                    if (step.wr) begin
                        if (r_held_v) begin
                            n_out = r_held;
                            n_ov  = 1'b1;
                        end
                        n_held   = step_res;
                        n_held_v = 1'b1;
                    end
                    n_rem = r_rem - 6'd1;
                    if (step.line_done || r_rem == 6'd1) begin
                        n_ended = step.ended;
                        if (step.ended) begin
                            n_halt = 1'b1;
                        end
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (!r_held_v) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out              = r_held;
                    n_out.last_of_run  = !r_held.bad_run;
                    n_out.end_of_image = r_ended && !r_held.bad_run;
                    n_ov               = 1'b1;
                    n_held_v           = 1'b0;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_await  <= 1'b0;
            r_pend   <= '0;
            r_halt   <= 1'b0;
            r_rem    <= '0;
            r_ended  <= 1'b0;
            r_held_v <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_await  <= n_await;
            r_pend   <= n_pend;
            r_halt   <= n_halt;
            r_rem    <= n_rem;
            r_ended  <= n_ended;
            r_held_v <= n_held_v;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val  <= n_val;
        r_held <= n_held;
        r_out  <= n_out;
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {6'd0, r_out.value, r_out.channel, r_out.column, r_out.row};
    assign o_m_tlast  = r_out.last_of_run;
    assign o_m_tuser  = {r_out.bad_run, r_out.end_of_image, r_out.fill_alpha};

`ifndef SYNTHESIS
    a_idle_no_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_held_v)
        else $error("held write left behind in idle");

    a_halt_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_halt && r_state == S_IDLE) |=> (r_state == S_IDLE))
        else $error("decoder started work after halting");

    a_run_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_rem != 6'd0))
        else $error("run stepping with no bytes left");

    a_bad_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[2]) |-> (!o_m_tlast && !o_m_tuser[1]))
        else $error("bad run item flagged as end of run");
`endif

endmodule

`default_nettype wire
